// File: sv/twt_pkg.sv
// ----------------------------------------------------------------------------
// twt_pkg: shared definitions for the threshold window trigger unit
// Default widths, trigger state codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package twt_pkg;

    // Default widths of a reading and of a millisecond timestamp.
    localparam int VALUE_BITS_DEF = 32;
    localparam int TIME_BITS_DEF  = 32;

    // Width of the configuration register index.
    localparam int CFG_INDEX_BITS = 3;

    // Reported trigger state.
    typedef enum logic [1:0] {
        TRIG_DISABLED  = 2'd0,
        TRIG_CLEAR     = 2'd1,
        TRIG_TRIGGERED = 2'd2
    } trig_state_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MODE_WINDOW  = 3'd0,
        CFG_INVERT_SENSE = 3'd1,
        CFG_LIMIT_LOW    = 3'd2,
        CFG_LIMIT_HIGH   = 3'd3,
        CFG_HYSTERESIS   = 3'd4,
        CFG_HOLD_MS      = 3'd5
    } cfg_index_t;

endpackage : twt_pkg

`default_nettype wire

// File: sv/threshold_window_trigger_unit.sv
// ----------------------------------------------------------------------------
// threshold_window_trigger_unit: threshold/window comparator with hold
// Compares each reading against a threshold or a window, widens the limits
// by a hysteresis tolerance while triggered, and keeps the triggered state
// for a programmable hold time. One result transaction per input transaction.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------------
//   cfg     | in        | cfg_wr_en          | cfg_index, cfg_data
//   in      | in        | in_valid/in_stall  | frame_valid, is_binary,
//           |           |                    | binary_level, reading, now_ms
//   out     | out       | out_valid/out_stall| trig_state, fired
//
// A transaction is registered at the input, evaluated from the input register
// and written to the result register; one transaction per cycle sustained
// while out_stall is low. The rate is set by the single compare-and-update path
// between the input register and the trigger state register.
// Reset clears all configuration registers, the state (disabled) and the
// hold timestamp. A stalled output holds its result; in_stall rises only when
// both the input register and the result register are full.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_window_trigger_unit
    import twt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int CFG_BITS   = (VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    // Configuration write port
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]       cfg_data,

    // Input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      frame_valid,
    input  wire logic                      is_binary,
    input  wire logic                      binary_level,
    input  wire logic signed [VALUE_BITS-1:0] reading,
    input  wire logic [TIME_BITS-1:0]      now_ms,

    // Output channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     trig_state,
    output logic                           fired
);

    localparam int EXT_BITS = VALUE_BITS + 1;

    // Configuration registers.
    logic                         mode_window_reg;
    logic                         invert_sense_reg;
    logic signed [VALUE_BITS-1:0] limit_low_reg;
    logic signed [VALUE_BITS-1:0] limit_high_reg;
    logic [VALUE_BITS-2:0]        hysteresis_reg;
    logic [TIME_BITS-1:0]         hold_ms_reg;

    // Trigger state.
    trig_state_t                  cur_state_reg;
    trig_state_t                  cur_state_next;
    logic [TIME_BITS-1:0]         trigger_time_reg;
    logic [TIME_BITS-1:0]         trigger_time_next;

    // Input register stage.
    logic                         s1_valid_reg;
    logic                         s1_frame_valid_reg;
    logic                         s1_is_binary_reg;
    logic                         s1_binary_level_reg;
    logic signed [VALUE_BITS-1:0] s1_reading_reg;
    logic [TIME_BITS-1:0]         s1_now_reg;

    // Result register stage.
    logic                         out_valid_reg;
    trig_state_t                  out_state_reg;
    trig_state_t                  out_state_next;
    logic                         out_fired_reg;
    logic                         out_fired_next;

    // Flow control.
    logic                         s2_load;
    logic                         s1_load;

    // Evaluation signals.
    logic                         was_trig;
    logic signed [EXT_BITS-1:0]   reading_x;
    logic signed [EXT_BITS-1:0]   tol_x;
    logic signed [EXT_BITS-1:0]   low_up;
    logic signed [EXT_BITS-1:0]   low_dn;
    logic signed [EXT_BITS-1:0]   high_up;
    logic signed [EXT_BITS-1:0]   high_dn;
    logic                         le_low;
    logic                         ge_low;
    logic                         le_high;
    logic                         ge_high;
    logic                         next_trig;
    logic [TIME_BITS-1:0]         now_eff;
    logic [TIME_BITS-1:0]         elapsed;
    logic                         hold_running;
    logic                         hold_on;
    logic                         take;

    // Configuration writes; values are truncated to each register's width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_window_reg  <= 1'b0;
            invert_sense_reg <= 1'b0;
            limit_low_reg    <= '0;
            limit_high_reg   <= '0;
            hysteresis_reg   <= '0;
            hold_ms_reg      <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MODE_WINDOW:  mode_window_reg  <= cfg_data[0];
                CFG_INVERT_SENSE: invert_sense_reg <= cfg_data[0];
                CFG_LIMIT_LOW:    limit_low_reg    <= cfg_data[VALUE_BITS-1:0];
                CFG_LIMIT_HIGH:   limit_high_reg   <= cfg_data[VALUE_BITS-1:0];
                CFG_HYSTERESIS:   hysteresis_reg   <= cfg_data[VALUE_BITS-2:0];
                CFG_HOLD_MS:      hold_ms_reg      <= cfg_data[TIME_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Pipeline advance: the result register takes a new transaction when it is
    // empty or its content leaves this cycle.
    assign s2_load  = !out_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_stall = !s1_load;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_frame_valid_reg  <= frame_valid;
            s1_is_binary_reg    <= is_binary;
            s1_binary_level_reg <= binary_level;
            s1_reading_reg      <= reading;
            s1_now_reg          <= now_ms;
        end
    end

    // Limits widened by the tolerance, computed one bit wider so they never wrap.
    assign was_trig  = (cur_state_reg == TRIG_TRIGGERED);
    assign reading_x = EXT_BITS'(s1_reading_reg);
    assign tol_x     = was_trig ? $signed({2'b00, hysteresis_reg}) : '0;
    assign low_up    = EXT_BITS'(limit_low_reg) + tol_x;
    assign low_dn    = EXT_BITS'(limit_low_reg) - tol_x;
    assign high_up   = EXT_BITS'(limit_high_reg) + tol_x;
    assign high_dn   = EXT_BITS'(limit_high_reg) - tol_x;
    assign le_low    = (reading_x <= low_up);
    assign ge_low    = (reading_x >= low_dn);
    assign le_high   = (reading_x <= high_up);
    assign ge_high   = (reading_x >= high_dn);

    // Trigger decision for the reading.
    always_comb
    begin
        if (!mode_window_reg)
        begin
            if (s1_is_binary_reg)
            begin
                next_trig = s1_binary_level_reg ^ invert_sense_reg;
            end
            else if (invert_sense_reg)
            begin
                next_trig = le_low;
            end
            else
            begin
                next_trig = ge_low;
            end
        end
        else if (!invert_sense_reg)
        begin
            next_trig = ge_low && le_high;
        end
        else
        begin
            next_trig = le_low || ge_high;
        end
    end

    // Hold timer: a zero timestamp counts as one so that zero marks no hold.
    assign now_eff      = (s1_now_reg == '0) ? TIME_BITS'(1) : s1_now_reg;
    assign elapsed      = now_eff - trigger_time_reg;
    assign hold_running = (trigger_time_reg != '0);
    assign hold_on      = hold_running && (elapsed < hold_ms_reg);

    // A change of state is taken on the first valid reading, on any trigger,
    // and on a release once no hold is running.
    assign take = s1_frame_valid_reg &&
                  ((cur_state_reg == TRIG_DISABLED) ||
                   ((next_trig != was_trig) && (next_trig || !hold_on)));

    // Next state and result.
    always_comb
    begin
        cur_state_next    = cur_state_reg;
        trigger_time_next = trigger_time_reg;
        if (s1_frame_valid_reg)
        begin
            if (take)
            begin
                cur_state_next    = next_trig ? TRIG_TRIGGERED : TRIG_CLEAR;
                trigger_time_next = (next_trig && (hold_ms_reg != '0)) ? now_eff : '0;
            end
            else if (!hold_on)
            begin
                trigger_time_next = '0;
            end
        end
        out_state_next = cur_state_next;
        out_fired_next = take;
    end

    // State and result registers, updated as the transaction moves out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg    <= TRIG_DISABLED;
            trigger_time_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else if (s2_load)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                cur_state_reg    <= cur_state_next;
                trigger_time_reg <= trigger_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            out_state_reg <= out_state_next;
            out_fired_reg <= out_fired_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign trig_state = out_state_reg;
    assign fired      = out_fired_reg;

    // A fired result always reports an enabled state.
    a_fired_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fired) |-> (trig_state != TRIG_DISABLED))
        else $error("fired result reports the disabled state");

    // Once enabled, the block never returns to the disabled state.
    a_stay_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_state_reg != TRIG_DISABLED) |=> (cur_state_reg != TRIG_DISABLED))
        else $error("trigger state returned to disabled");

    // A running hold exists only while triggered.
    a_hold_triggered: assert property (@(posedge clk) disable iff (!rst_n)
        (trigger_time_reg != '0) |-> (cur_state_reg == TRIG_TRIGGERED))
        else $error("hold running outside the triggered state");

    // The input stalls only with a full input register and a blocked result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

endmodule : threshold_window_trigger_unit

`default_nettype wire
